>>> rtl/nmea_rmc_sentence_parser_assert.svh
// assertion helpers shared by the checker
`ifndef NMEA_RMC_SENTENCE_PARSER_ASSERT_SVH
`define NMEA_RMC_SENTENCE_PARSER_ASSERT_SVH

// checked on every edge outside reset
`define RMC_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define RMC_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/rmc_pkg.sv
package rmc_pkg;

  localparam int FRAC_DIGITS = 5;
  localparam int JOB_Q_DEPTH = 4;
  localparam int REC_Q_DEPTH = 2;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_N      = 8'h4E;
  localparam logic [7:0] CH_W      = 8'h57;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  localparam logic [3:0] FLD_TIME   = 4'd1;
  localparam logic [3:0] FLD_STATUS = 4'd2;
  localparam logic [3:0] FLD_LAT    = 4'd3;
  localparam logic [3:0] FLD_NS     = 4'd4;
  localparam logic [3:0] FLD_LON    = 4'd5;
  localparam logic [3:0] FLD_EW     = 4'd6;
  localparam logic [3:0] FLD_SPEED  = 4'd7;
  localparam logic [3:0] FLD_DATE   = 4'd9;
  localparam logic [3:0] FLD_FULL   = 4'd12;
  localparam logic [3:0] FLD_LAST   = 4'd15;

  localparam logic [16:0] INT_CLAMP  = 17'd99999;
  localparam logic [16:0] SPD_I_SAT  = 17'd10000;
  localparam logic [17:0] R_DIV100   = 18'd167773;
  localparam logic [28:0] R_DIV15    = 29'd286331153;
  localparam logic [23:0] R_DIV78125 = 24'd14073748;
  localparam logic [23:0] E7         = 24'd10000000;
  localparam logic [10:0] KNOT_KMH   = 11'd1852;
  localparam logic [22:0] HALF_E7    = 23'd5000000;
  localparam logic [29:0] LAT_MAX    = 30'd900000000;
  localparam logic [30:0] LON_MAX    = 31'd1800000000;
  localparam logic [24:0] SPEED_MAX  = 25'd18519999;

  typedef enum logic [1:0] {JOB_LAT, JOB_LON, JOB_SPD, JOB_EMIT} job_kind_t;

  typedef struct packed {
    job_kind_t        kind;
    logic [16:0]      int_part;
    logic [23:0]      frac_part;
    logic [2:0]       frac_cnt;
    logic             num_bad;
    logic             ck;
    logic             valid;
    logic [7:0]       status;
    logic [1:0]       hemi;
    logic [14:0][3:0] digits;
    logic             time_bad;
    logic [3:0]       time_len;
    logic             date_bad;
    logic [3:0]       date_len;
  } job_t;

  typedef struct packed {
    logic        checksum_ok;
    logic [7:0]  fix_status;
    logic [30:0] latitude_e7;
    logic [31:0] longitude_e7;
    logic [24:0] speed_kmh_milli;
    logic [4:0]  utc_hour;
    logic [5:0]  utc_minute;
    logic [5:0]  utc_second;
    logic [9:0]  utc_millisecond;
    logic [4:0]  date_day;
    logic [3:0]  date_month;
    logic [6:0]  date_year;
  } rec_t;

  function automatic logic [23:0] pow10(input logic [2:0] k);
    logic [23:0] p;
    unique case (k)
      3'd0: p = 24'd1;
      3'd1: p = 24'd10;
      3'd2: p = 24'd100;
      3'd3: p = 24'd1000;
      3'd4: p = 24'd10000;
      3'd5: p = 24'd100000;
      3'd6: p = 24'd1000000;
      default: p = 24'd10000000;
    endcase
    return p;
  endfunction

  // {ok, value}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] h;
    if (c >= 8'h30 && c <= 8'h39) h = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h41 && c <= 8'h46) h = {1'b1, 4'(c - 8'h37)};
    else if (c >= 8'h61 && c <= 8'h66) h = {1'b1, 4'(c - 8'h57)};
    else h = 5'd0;
    return h;
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] mo, input logic leap);
    logic [4:0] n;
    unique case (mo)
      4'd2: n = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
      default: n = 5'd31;
    endcase
    return n;
  endfunction

endpackage

>>> rtl/nmea_rmc_sentence_parser.sv
// nmea rmc sentence parser
// input channel: one ascii byte per beat on char_byte, taken when push is
//   high and full is low. bytes outside a sentence (before a '$') are dropped
// output channel: one position record per cr/lf inside a sentence; the
//   oldest record sits on the result ports while empty is low and leaves on
//   a beat with pop high
// throughput: one byte per cycle sustained while full stays low; the front
//   parser takes every accepted byte and hands number fields and end-of-line
//   snapshots to a 4-entry job queue
// record path: from the cr/lf beat through the job queue write, five
//   conversion stages and the record queue write
// the back end is a 5-stage pipeline that turns latitude, longitude and
//   speed fields into fixed point one job per cycle while it is not stalled,
//   in order, so the record sees the conversions of its own sentence
// stall: if pop stays low the 2-entry record queue fills, the pipeline holds
//   at the record job, the job queue fills and full goes high
// reset: rst (synchronous) empties both queues and drops any half-parsed
//   sentence; no clearing pass, the block takes bytes on the next cycle
module nmea_rmc_sentence_parser #(
  parameter int JOB_DEPTH = rmc_pkg::JOB_Q_DEPTH,
  parameter int REC_DEPTH = rmc_pkg::REC_Q_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         char_byte,
  output logic               empty,
  input  logic               pop,
  output logic               checksum_ok,
  output logic [7:0]         fix_status,
  output logic signed [30:0] latitude_e7,
  output logic signed [31:0] longitude_e7,
  output logic [24:0]        speed_kmh_milli,
  output logic [4:0]         utc_hour,
  output logic [5:0]         utc_minute,
  output logic [5:0]         utc_second,
  output logic [9:0]         utc_millisecond,
  output logic [4:0]         date_day,
  output logic [3:0]         date_month,
  output logic [6:0]         date_year
);

  logic          byte_acc;
  logic          job_push, jq_full, jq_empty, jq_pop;
  rmc_pkg::job_t job_in, job_out;
  rmc_pkg::rec_t rec_in, rec_out;
  logic          rec_push, rec_full;

  // a byte beat is taken only while the job queue has room
  assign full     = jq_full;
  assign byte_acc = push && !jq_full;

  rmc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .byte_acc  (byte_acc),
    .char_byte (char_byte),
    .job       (job_in),
    .job_push  (job_push)
  );

  rmc_fifo #(
    .WIDTH ($bits(rmc_pkg::job_t)),
    .DEPTH (JOB_DEPTH)
  ) u_job_q (
    .clk     (clk),
    .rst     (rst),
    .push    (job_push),
    .wr_data (job_in),
    .full    (jq_full),
    .pop     (jq_pop),
    .rd_data (job_out),
    .empty   (jq_empty)
  );

  rmc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .jq_data  (job_out),
    .jq_empty (jq_empty),
    .jq_pop   (jq_pop),
    .rec      (rec_in),
    .rec_push (rec_push),
    .rec_full (rec_full)
  );

  // record queue decouples the pipeline from the consumer
  rmc_fifo #(
    .WIDTH ($bits(rmc_pkg::rec_t)),
    .DEPTH (REC_DEPTH)
  ) u_rec_q (
    .clk     (clk),
    .rst     (rst),
    .push    (rec_push),
    .wr_data (rec_in),
    .full    (rec_full),
    .pop     (pop),
    .rd_data (rec_out),
    .empty   (empty)
  );

  assign checksum_ok     = rec_out.checksum_ok;
  assign fix_status      = rec_out.fix_status;
  assign latitude_e7     = $signed(rec_out.latitude_e7);
  assign longitude_e7    = $signed(rec_out.longitude_e7);
  assign speed_kmh_milli = rec_out.speed_kmh_milli;
  assign utc_hour        = rec_out.utc_hour;
  assign utc_minute      = rec_out.utc_minute;
  assign utc_second      = rec_out.utc_second;
  assign utc_millisecond = rec_out.utc_millisecond;
  assign date_day        = rec_out.date_day;
  assign date_month      = rec_out.date_month;
  assign date_year       = rec_out.date_year;

endmodule

>>> rtl/rmc_fifo.sv
module rmc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    rd_ptr, wr_ptr;
  logic [CW-1:0]    count;
  logic             do_push, do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) count <= count + CW'(1);
      else if (do_pop && !do_push) count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= wr_data;
  end

endmodule

>>> rtl/rmc_front.sv
module rmc_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          byte_acc,
  input  logic [7:0]    char_byte,
  output rmc_pkg::job_t job,
  output logic          job_push
);

  logic             in_sentence, star_seen, seen_point, num_bad;
  logic             time_bad, date_bad;
  logic [3:0]       field_index, char_pos, time_len, date_len;
  logic [7:0]       running_xor, rx_ck, status_char;
  logic [1:0]       after_star, hemi;
  logic [16:0]      int_part;
  logic [23:0]      frac_part;
  logic [2:0]       frac_cnt;
  logic [14:0][3:0] digits;

  logic       is_digit, is_eol, conv_field, ck;
  logic [3:0] dval;
  logic [4:0] hx;
  logic [19:0] int_wide;
  logic [16:0] int_next;
  logic [27:0] frac_wide;

  always_comb begin
    is_digit   = (char_byte >= 8'h30) && (char_byte <= 8'h39);
    dval       = char_byte[3:0];
    is_eol     = (char_byte == rmc_pkg::CH_CR) || (char_byte == rmc_pkg::CH_LF);
    hx         = rmc_pkg::hex_val(char_byte);
    conv_field = (field_index == rmc_pkg::FLD_LAT) || (field_index == rmc_pkg::FLD_LON) ||
                 (field_index == rmc_pkg::FLD_SPEED);
    int_wide   = 20'(int_part) * 20'd10 + 20'(dval);
    int_next   = (int_wide > 20'(rmc_pkg::INT_CLAMP)) ? rmc_pkg::INT_CLAMP : int_wide[16:0];
    frac_wide  = 28'(frac_part) * 28'd10 + 28'(dval);
    ck         = star_seen && (after_star == 2'd1 || after_star == 2'd2) &&
                 (rx_ck == running_xor);
  end

  // job snapshot: field end (comma or star) of a number field, or end of line
  always_comb begin
    job           = '0;
    job.int_part  = int_part;
    job.frac_part = frac_part;
    job.frac_cnt  = frac_cnt;
    job.num_bad   = num_bad;
    job.ck        = ck;
    job.valid     = ck && (field_index >= rmc_pkg::FLD_FULL);
    job.status    = status_char;
    job.hemi      = hemi;
    job.digits    = digits;
    job.time_bad  = time_bad;
    job.time_len  = time_len;
    job.date_bad  = date_bad;
    job.date_len  = date_len;
    if (is_eol) job.kind = rmc_pkg::JOB_EMIT;
    else if (field_index == rmc_pkg::FLD_LAT) job.kind = rmc_pkg::JOB_LAT;
    else if (field_index == rmc_pkg::FLD_LON) job.kind = rmc_pkg::JOB_LON;
    else job.kind = rmc_pkg::JOB_SPD;
    job_push = byte_acc && in_sentence && (char_byte != rmc_pkg::CH_DOLLAR) &&
               (is_eol || (!star_seen && conv_field &&
                ((char_byte == rmc_pkg::CH_STAR) || (char_byte == rmc_pkg::CH_COMMA))));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_sentence <= 1'b0;
      field_index <= '0;
      star_seen   <= 1'b0;
      after_star  <= '0;
      rx_ck       <= '0;
      running_xor <= '0;
    end else if (byte_acc) begin
      if (char_byte == rmc_pkg::CH_DOLLAR) begin
        in_sentence <= 1'b1;
        field_index <= '0;
        running_xor <= '0;
        after_star  <= '0;
        rx_ck       <= '0;
        star_seen   <= 1'b0;
        status_char <= rmc_pkg::CH_SPACE;
        hemi        <= '0;
        time_bad    <= 1'b0;
        date_bad    <= 1'b0;
        time_len    <= '0;
        date_len    <= '0;
        digits      <= '0;
        char_pos    <= '0;
        int_part    <= '0;
        frac_part   <= '0;
        frac_cnt    <= '0;
        seen_point  <= 1'b0;
        num_bad     <= 1'b0;
      end else if (in_sentence) begin
        if (is_eol) begin
          in_sentence <= 1'b0;
        end else if (star_seen) begin
          if (!hx[4] || after_star >= 2'd2) begin
            after_star <= 2'd3;
          end else begin
            rx_ck      <= {rx_ck[3:0], hx[3:0]};
            after_star <= after_star + 2'd1;
          end
        end else if (char_byte == rmc_pkg::CH_STAR) begin
          star_seen <= 1'b1;
        end else begin
          running_xor <= running_xor ^ char_byte;
          if (char_byte == rmc_pkg::CH_COMMA) begin
            if (field_index != rmc_pkg::FLD_LAST) field_index <= field_index + 4'd1;
            char_pos   <= '0;
            int_part   <= '0;
            frac_part  <= '0;
            frac_cnt   <= '0;
            seen_point <= 1'b0;
            num_bad    <= 1'b0;
            if (field_index == rmc_pkg::FLD_TIME) status_char <= '0;
          end else begin
            if (char_pos != 4'd15) char_pos <= char_pos + 4'd1;
            unique case (field_index)
              rmc_pkg::FLD_TIME: begin
                if (time_len != 4'd15) time_len <= time_len + 4'd1;
                if (char_pos < 4'd6) begin
                  if (is_digit) digits[char_pos] <= dval;
                  else time_bad <= 1'b1;
                end else if (char_pos == 4'd6) begin
                  if (char_byte != rmc_pkg::CH_DOT) time_bad <= 1'b1;
                end else if (char_pos < 4'd10) begin
                  if (is_digit) digits[char_pos - 4'd1] <= dval;
                  else time_bad <= 1'b1;
                end else begin
                  time_bad <= 1'b1;
                end
              end
              rmc_pkg::FLD_STATUS: begin
                if (char_pos == 4'd0) status_char <= char_byte;
              end
              rmc_pkg::FLD_LAT, rmc_pkg::FLD_LON, rmc_pkg::FLD_SPEED: begin
                if (is_digit) begin
                  if (!seen_point) begin
                    int_part <= int_next;
                  end else if (frac_cnt < 3'(rmc_pkg::FRAC_DIGITS)) begin
                    frac_part <= frac_wide[23:0];
                    frac_cnt  <= frac_cnt + 3'd1;
                  end
                end else if (char_byte == rmc_pkg::CH_DOT && !seen_point) begin
                  seen_point <= 1'b1;
                end else begin
                  num_bad <= 1'b1;
                end
              end
              rmc_pkg::FLD_NS: begin
                hemi[0] <= (char_pos == 4'd0) && (char_byte == rmc_pkg::CH_N);
              end
              rmc_pkg::FLD_EW: begin
                hemi[1] <= (char_pos == 4'd0) && (char_byte == rmc_pkg::CH_W);
              end
              rmc_pkg::FLD_DATE: begin
                if (date_len != 4'd15) date_len <= date_len + 4'd1;
                if (char_pos < 4'd6 && is_digit) digits[4'd9 + char_pos] <= dval;
                else date_bad <= 1'b1;
              end
              default: begin
              end
            endcase
          end
        end
      end
    end
  end

endmodule

>>> rtl/rmc_back.sv
module rmc_back (
  input  logic          clk,
  input  logic          rst,
  input  rmc_pkg::job_t jq_data,
  input  logic          jq_empty,
  output logic          jq_pop,
  output rmc_pkg::rec_t rec,
  output logic          rec_push,
  input  logic          rec_full
);

  logic          adv;
  logic          v1, v2, v3, v4, v5;
  rmc_pkg::job_t j1, j2, j3, j4, j5;
  logic [9:0]    s1_hi;
  logic [23:0]   s1_fs, s2_fs;
  logic [6:0]    s2_lo;
  logic [33:0]   s2_hie7, s3_hie7, s4_hie7, s5_hie7;
  logic [27:0]   s2_sb, s3_sb, s4_sb, s5_sb;
  logic [34:0]   s2_t;
  logic [27:0]   s3_z, s4_z;
  logic [24:0]   s4_q, s5_q;

  logic [29:0]   lat_acc;
  logic [30:0]   lon_acc;
  logic [24:0]   spd_acc;

  // stage logic
  logic [34:0] hi_prod;
  logic [47:0] fs_prod;
  logic [16:0] hi100, lo_w;
  logic [29:0] n_geo;
  logic [56:0] pg;
  logic [51:0] ps;
  logic [27:0] dvsr, qd, rem;
  logic [24:0] q_fix;
  logic [34:0] geo_total, geo_lim;
  logic [30:0] geo_val;
  logic [27:0] spd_sum;
  logic [24:0] spd_val;

  assign adv      = !(v5 && j5.kind == rmc_pkg::JOB_EMIT && rec_full);
  assign jq_pop   = adv && !jq_empty;
  assign rec_push = adv && v5 && (j5.kind == rmc_pkg::JOB_EMIT);

  always_comb begin
    hi_prod = 35'(jq_data.int_part) * 35'(rmc_pkg::R_DIV100);
    fs_prod = 48'(jq_data.frac_part) * 48'(rmc_pkg::pow10(3'(3'd7 - jq_data.frac_cnt)));
    hi100   = 17'(s1_hi) * 17'd100;
    lo_w    = j1.int_part - hi100;
    n_geo   = 30'(s2_lo) * 30'(rmc_pkg::E7) + 30'(s2_fs) + 30'd30;
    pg      = 57'(s3_z) * 57'(rmc_pkg::R_DIV15);
    ps      = 52'(s3_z) * 52'(rmc_pkg::R_DIV78125);
    dvsr    = (j4.kind == rmc_pkg::JOB_SPD) ? 28'd78125 : 28'd15;
    qd      = 28'(s4_q) * dvsr;
    rem     = s4_z - qd;
    q_fix   = s4_q + 25'(rem >= dvsr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (adv) begin
      v1 <= !jq_empty;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // integer degrees split and fraction scaled to seven digits
      j1    <= jq_data;
      s1_hi <= hi_prod[33:24];
      s1_fs <= fs_prod[23:0];
      j2      <= j1;
      s2_lo   <= lo_w[6:0];
      s2_fs   <= s1_fs;
      s2_hie7 <= 34'(s1_hi) * 34'(rmc_pkg::E7);
      s2_sb   <= 28'(j1.int_part) * 28'(rmc_pkg::KNOT_KMH);
      s2_t    <= 35'(s1_fs) * 35'(rmc_pkg::KNOT_KMH) + 35'(rmc_pkg::HALF_E7);
      // divide by 60 as /4 then /15, speed fraction by 1e7 as /128 then /78125
      j3      <= j2;
      s3_hie7 <= s2_hie7;
      s3_sb   <= s2_sb;
      s3_z    <= (j2.kind == rmc_pkg::JOB_SPD) ? s2_t[34:7] : n_geo[29:2];
      j4      <= j3;
      s4_hie7 <= s3_hie7;
      s4_sb   <= s3_sb;
      s4_z    <= s3_z;
      s4_q    <= (j3.kind == rmc_pkg::JOB_SPD) ? 25'(ps[51:40]) : pg[56:32];
      j5      <= j4;
      s5_hie7 <= s4_hie7;
      s5_sb   <= s4_sb;
      s5_q    <= q_fix;
    end
  end

  always_comb begin
    geo_total = 35'(s5_hie7) + 35'(s5_q);
    geo_lim   = (j5.kind == rmc_pkg::JOB_LAT) ? 35'(rmc_pkg::LAT_MAX) : 35'(rmc_pkg::LON_MAX);
    if (j5.num_bad) geo_val = '0;
    else if (geo_total > geo_lim) geo_val = geo_lim[30:0];
    else geo_val = geo_total[30:0];
    spd_sum = s5_sb + 28'(s5_q);
    if (j5.num_bad) spd_val = '0;
    else if (j5.int_part >= rmc_pkg::SPD_I_SAT || spd_sum > 28'(rmc_pkg::SPEED_MAX))
      spd_val = rmc_pkg::SPEED_MAX;
    else spd_val = spd_sum[24:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lat_acc <= '0;
      lon_acc <= '0;
      spd_acc <= '0;
    end else if (adv && v5) begin
      unique case (j5.kind)
        rmc_pkg::JOB_LAT: lat_acc <= geo_val[29:0];
        rmc_pkg::JOB_LON: lon_acc <= geo_val;
        rmc_pkg::JOB_SPD: spd_acc <= spd_val;
        default: begin
        end
      endcase
    end
  end

  // record assembly from the end-of-line snapshot
  logic [6:0]  hh, mi, ss, dd, mo, yy;
  logic [9:0]  ms;
  logic        tok, dok, leap;
  logic [4:0]  lim;
  logic [31:0] lat32, lon32;

  always_comb begin
    hh   = 7'(j5.digits[0]) * 7'd10 + 7'(j5.digits[1]);
    mi   = 7'(j5.digits[2]) * 7'd10 + 7'(j5.digits[3]);
    ss   = 7'(j5.digits[4]) * 7'd10 + 7'(j5.digits[5]);
    ms   = 10'(j5.digits[6]) * 10'd100 + 10'(j5.digits[7]) * 10'd10 + 10'(j5.digits[8]);
    dd   = 7'(j5.digits[9]) * 7'd10 + 7'(j5.digits[10]);
    mo   = 7'(j5.digits[11]) * 7'd10 + 7'(j5.digits[12]);
    yy   = 7'(j5.digits[13]) * 7'd10 + 7'(j5.digits[14]);
    tok  = !j5.time_bad && (j5.time_len == 4'd6 ||
           (j5.time_len >= 4'd7 && j5.time_len <= 4'd10)) &&
           hh <= 7'd23 && mi <= 7'd59 && ss <= 7'd59;
    // year 00 reads as 1900, not a leap year
    leap = (yy[1:0] == 2'd0) && (yy != 7'd0);
    lim  = rmc_pkg::month_days(mo[3:0], leap);
    dok  = !j5.date_bad && j5.date_len == 4'd6 && mo >= 7'd1 && mo <= 7'd12 &&
           dd >= 7'd1 && dd <= 7'(lim);
    lat32 = j5.hemi[0] ? 32'd0 - 32'(lat_acc) : 32'(lat_acc);
    lon32 = j5.hemi[1] ? 32'd0 - 32'(lon_acc) : 32'(lon_acc);

    rec.checksum_ok     = j5.ck;
    rec.fix_status      = j5.valid ? j5.status : rmc_pkg::CH_SPACE;
    rec.latitude_e7     = j5.valid ? lat32[30:0] : '0;
    rec.longitude_e7    = j5.valid ? lon32 : '0;
    rec.speed_kmh_milli = j5.valid ? spd_acc : '0;
    rec.utc_hour        = tok ? hh[4:0] : '0;
    rec.utc_minute      = tok ? mi[5:0] : '0;
    rec.utc_second      = tok ? ss[5:0] : '0;
    rec.utc_millisecond = tok ? ms : '0;
    rec.date_day        = dok ? dd[4:0] : 5'd1;
    rec.date_month      = dok ? mo[3:0] : 4'd1;
    rec.date_year       = dok ? yy : 7'd1;
  end

endmodule

>>> rtl/rmc_checker.sv
`include "nmea_rmc_sentence_parser_assert.svh"

module rmc_checker (
  input logic               clk,
  input logic               rst,
  input logic               push,
  input logic               full,
  input logic [7:0]         char_byte,
  input logic               empty,
  input logic               pop,
  input logic               checksum_ok,
  input logic [7:0]         fix_status,
  input logic signed [30:0] latitude_e7,
  input logic signed [31:0] longitude_e7,
  input logic [24:0]        speed_kmh_milli,
  input logic [4:0]         utc_hour,
  input logic [5:0]         utc_minute,
  input logic [5:0]         utc_second,
  input logic [9:0]         utc_millisecond,
  input logic [4:0]         date_day,
  input logic [3:0]         date_month,
  input logic [6:0]         date_year
);

  // reset empties the record queue
  `RMC_ASSERT_ALWAYS(a_reset_empty, clk, (rst |=> empty), "records left after reset")

  // a waiting record is not replaced while the consumer stalls
  `RMC_ASSERT(a_hold, clk, rst, ((!empty && !pop) |=> (!empty && $stable(checksum_ok) && $stable(latitude_e7) && $stable(utc_second))), "record changed under stall")

  // failed checksum clears status, position and speed
  `RMC_ASSERT(a_bad_ck, clk, rst, ((!empty && !checksum_ok) |-> (fix_status == 8'h20 && latitude_e7 == 31'sd0 && longitude_e7 == 32'sd0 && speed_kmh_milli == 25'd0)), "invalid record not cleared")

  // time, date and speed stay in range
  `RMC_ASSERT(a_range, clk, rst, (!empty |-> (utc_hour <= 5'd23 && utc_minute <= 6'd59 && utc_second <= 6'd59 && utc_millisecond <= 10'd999 && date_month >= 4'd1 && date_month <= 4'd12 && date_day >= 5'd1 && speed_kmh_milli <= 25'd18519999)), "record field out of range")

endmodule

bind nmea_rmc_sentence_parser rmc_checker u_rmc_checker (.*);

>>> tb/tb_nmea_rmc_sentence_parser.sv
`timescale 1ns / 1ps

// record as the block should report it
typedef struct {
  bit        ck;
  bit [7:0]  status;
  bit [30:0] lat;
  bit [31:0] lon;
  bit [24:0] spd;
  bit [4:0]  hh;
  bit [5:0]  mi;
  bit [5:0]  ss;
  bit [9:0]  ms;
  bit [4:0]  dd;
  bit [3:0]  mo;
  bit [6:0]  yy;
} fix_rec_t;

// byte-level predictor of the parser plus the queue of records still owed
class rmc_scoreboard;
  fix_rec_t owed[$];
  int errors;
  bit in_sent, star, num_bad, t_bad, d_bad;
  bit [3:0] fld, cpos, t_len, d_len;
  bit [7:0] xsum, rx_sum, status;
  bit [1:0] star_digits, hemi;
  bit [31:0] lat_mag, lon_mag, spd_mag, int_acc, frac_acc;
  bit [2:0] frac_cnt;
  bit pt;
  bit [3:0] dig[15];

  function new();
    errors = 0;
    begin_sentence();
    in_sent = 0;
  endfunction

  function void clear_number();
    cpos = 0; int_acc = 0; frac_acc = 0; frac_cnt = 0; pt = 0; num_bad = 0;
  endfunction

  function void begin_sentence();
    in_sent = 1; fld = 0; xsum = 0; star_digits = 0; rx_sum = 0; star = 0;
    status = rmc_pkg::CH_SPACE; lat_mag = 0; lon_mag = 0; spd_mag = 0; hemi = 0;
    t_bad = 0; d_bad = 0; t_len = 0; d_len = 0;
    foreach (dig[i]) dig[i] = 0;
    clear_number();
  endfunction

  function bit [63:0] pw(bit [2:0] k);
    bit [63:0] p;
    p = 1;
    repeat (k) p = p * 10;
    return p;
  endfunction

  function bit [31:0] geo(bit [63:0] limit);
    bit [63:0] p, m, t;
    if (num_bad) return 0;
    p = pw(frac_cnt);
    m = 64'(int_acc % 100) * p + frac_acc;
    t = 64'(int_acc / 100) * 10000000 + (m * 10000000 + 30 * p) / (60 * p);
    return (t > limit) ? limit[31:0] : t[31:0];
  endfunction

  function bit [31:0] knots_to_kmh();
    bit [63:0] p, v;
    if (num_bad) return 0;
    p = pw(frac_cnt);
    v = ((64'(int_acc) * p + frac_acc) * 1852 + p / 2) / p;
    return (v > 18519999) ? 32'd18519999 : v[31:0];
  endfunction

  function void close_field();
    if (fld == rmc_pkg::FLD_LAT) lat_mag = geo(900000000);
    else if (fld == rmc_pkg::FLD_LON) lon_mag = geo(1800000000);
    else if (fld == rmc_pkg::FLD_SPEED) spd_mag = knots_to_kmh();
  endfunction

  function int hexv(bit [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "A" && c <= "F") return c - "A" + 10;
    if (c >= "a" && c <= "f") return c - "a" + 10;
    return -1;
  endfunction

  function void field_byte(bit [7:0] c);
    bit isd;
    isd = (c >= "0" && c <= "9");
    case (fld)
      rmc_pkg::FLD_TIME: begin
        if (t_len < 15) t_len++;
        if (cpos < 6) begin
          if (isd) dig[cpos] = c - "0"; else t_bad = 1;
        end else if (cpos == 6) begin
          if (c != rmc_pkg::CH_DOT) t_bad = 1;
        end else if (cpos < 10) begin
          if (isd) dig[cpos - 1] = c - "0"; else t_bad = 1;
        end else t_bad = 1;
      end
      rmc_pkg::FLD_STATUS: if (cpos == 0) status = c;
      rmc_pkg::FLD_LAT, rmc_pkg::FLD_LON, rmc_pkg::FLD_SPEED: begin
        if (isd) begin
          if (!pt) begin
            int_acc = int_acc * 10 + (c - "0");
            if (int_acc > 99999) int_acc = 99999;
          end else if (frac_cnt < rmc_pkg::FRAC_DIGITS) begin
            frac_acc = frac_acc * 10 + (c - "0");
            frac_cnt++;
          end
        end else if (c == rmc_pkg::CH_DOT && !pt) pt = 1;
        else num_bad = 1;
      end
      rmc_pkg::FLD_NS: hemi[0] = (cpos == 0 && c == rmc_pkg::CH_N);
      rmc_pkg::FLD_EW: hemi[1] = (cpos == 0 && c == rmc_pkg::CH_W);
      rmc_pkg::FLD_DATE: begin
        if (d_len < 15) d_len++;
        if (cpos < 6 && isd) dig[9 + cpos] = c - "0"; else d_bad = 1;
      end
      default: ;
    endcase
    if (cpos < 15) cpos++;
  endfunction

  function void make_record();
    fix_rec_t r;
    bit ok, tok, dok;
    int hh, mi, ss, ms, dd, mo, yy, lim;
    ok = star && (star_digits == 1 || star_digits == 2) && rx_sum == xsum;
    hh = dig[0] * 10 + dig[1]; mi = dig[2] * 10 + dig[3]; ss = dig[4] * 10 + dig[5];
    ms = dig[6] * 100 + dig[7] * 10 + dig[8];
    dd = dig[9] * 10 + dig[10]; mo = dig[11] * 10 + dig[12]; yy = dig[13] * 10 + dig[14];
    tok = !t_bad && (t_len >= 6 && t_len <= 10) && hh <= 23 && mi <= 59 && ss <= 59;
    dok = !d_bad && d_len == 6 && mo >= 1 && mo <= 12 && dd >= 1;
    if (dok) begin
      case (mo)
        2: lim = (yy % 4 == 0 && yy != 0) ? 29 : 28;
        4, 6, 9, 11: lim = 30;
        default: lim = 31;
      endcase
      if (dd > lim) dok = 0;
    end
    r.ck = ok;
    ok = ok && fld >= rmc_pkg::FLD_FULL;
    r.status = ok ? status : rmc_pkg::CH_SPACE;
    r.lat = !ok ? 31'd0 : (hemi[0] ? 31'(-lat_mag) : 31'(lat_mag));
    r.lon = !ok ? 32'd0 : (hemi[1] ? -lon_mag : lon_mag);
    r.spd = ok ? spd_mag[24:0] : 25'd0;
    r.hh = tok ? 5'(hh) : 5'd0; r.mi = tok ? 6'(mi) : 6'd0;
    r.ss = tok ? 6'(ss) : 6'd0; r.ms = tok ? 10'(ms) : 10'd0;
    r.dd = dok ? 5'(dd) : 5'd1; r.mo = dok ? 4'(mo) : 4'd1; r.yy = dok ? 7'(yy) : 7'd1;
    owed.push_back(r);
  endfunction

  // note one accepted input byte
  function void take_byte(bit [7:0] c);
    int h;
    if (c == rmc_pkg::CH_DOLLAR) begin
      begin_sentence();
      return;
    end
    if (!in_sent) return;
    if (c == rmc_pkg::CH_CR || c == rmc_pkg::CH_LF) begin
      make_record();
      in_sent = 0;
    end else if (star) begin
      h = hexv(c);
      if (h < 0 || star_digits >= 2) star_digits = 3;
      else begin
        rx_sum = {rx_sum[3:0], h[3:0]};
        star_digits++;
      end
    end else if (c == rmc_pkg::CH_STAR) begin
      close_field();
      star = 1;
    end else begin
      xsum ^= c;
      if (c == rmc_pkg::CH_COMMA) begin
        close_field();
        if (fld < 15) fld++;
        clear_number();
        if (fld == rmc_pkg::FLD_STATUS) status = 0;
      end else field_byte(c);
    end
  endfunction

  function void cmp(string nm, longint e, longint a);
    if (e != a) begin
      $display("%0t mismatch %s: expected %0d actual %0d", $time, nm, e, a);
      errors++;
    end
  endfunction

  // check one popped record against the oldest owed one
  function void check_record(fix_rec_t a);
    fix_rec_t e;
    if (owed.size() == 0) begin
      $display("%0t mismatch: record popped with none expected", $time);
      errors++;
      return;
    end
    e = owed.pop_front();
    cmp("checksum_ok", e.ck, a.ck);
    cmp("fix_status", e.status, a.status);
    cmp("latitude_e7", e.lat, a.lat);
    cmp("longitude_e7", e.lon, a.lon);
    cmp("speed_kmh_milli", e.spd, a.spd);
    cmp("utc_hour", e.hh, a.hh);
    cmp("utc_minute", e.mi, a.mi);
    cmp("utc_second", e.ss, a.ss);
    cmp("utc_millisecond", e.ms, a.ms);
    cmp("date_day", e.dd, a.dd);
    cmp("date_month", e.mo, a.mo);
    cmp("date_year", e.yy, a.yy);
  endfunction
endclass

module tb_nmea_rmc_sentence_parser;
  logic clk = 0;
  logic rst = 1;
  logic push = 0;
  logic pop = 0;
  logic [7:0] char_byte = 0;
  logic full, empty, checksum_ok;
  logic [7:0] fix_status;
  logic signed [30:0] latitude_e7;
  logic signed [31:0] longitude_e7;
  logic [24:0] speed_kmh_milli;
  logic [4:0] utc_hour, date_day;
  logic [5:0] utc_minute, utc_second;
  logic [9:0] utc_millisecond;
  logic [3:0] date_month;
  logic [6:0] date_year;

  rmc_scoreboard fixes = new();
  // no idling once the last stretch of stimulus starts
  bit calm = 0;
  // asks the receiver for one long hold of pop
  bit hold_pop = 0;
  // byte stream still to offer
  byte unsigned stream[$];
  // bytes taken by the block so far
  int sent = 0;

  nmea_rmc_sentence_parser dut (.*);

  always #2 clk = ~clk;

  // receiver: random pop bursts, sampled at the rising edge
  always @(posedge clk) begin
    if (!rst && pop && !empty)
      fixes.check_record('{checksum_ok, fix_status, latitude_e7, longitude_e7,
                           speed_kmh_milli, utc_hour, utc_minute, utc_second,
                           utc_millisecond, date_day, date_month, date_year});
  end

  initial begin : receiver
    int n;
    bit held;
    held = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_pop && !held) begin
        // long stall counted here while the sender keeps offering bytes
        pop <= 0;
        repeat (300) @(negedge clk);
        held = 1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 4);
        pop <= 0;
        repeat (n) @(negedge clk);
      end else begin
        pop <= 1;
        @(negedge clk);
      end
    end
  end

  // offer one byte until it is taken, with random gaps before it
  task automatic send_byte(byte unsigned c);
    if (!calm && $urandom_range(0, 7) == 0) begin
      push <= 0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    push <= 1;
    char_byte <= c;
    do @(posedge clk); while (full);
    fixes.take_byte(c);
    sent++;
    @(negedge clk);
  endtask

  task automatic add_text(string s);
    foreach (s[i]) stream.push_back(s[i]);
  endtask

  function automatic string hex2(bit [7:0] v);
    return $sformatf("%02X", v);
  endfunction

  // full sentence around the given body, with a correct checksum unless good_ck is clear
  task automatic add_sentence(string body, bit good_ck = 1);
    bit [7:0] x;
    x = 0;
    foreach (body[i]) x ^= body[i];
    if (!good_ck) x ^= 8'h01 << $urandom_range(0, 7);
    add_text({"$", body, "*", ($urandom_range(0, 1) ? hex2(x) : $sformatf("%02x", x)),
              ($urandom_range(0, 1) ? "\r\n" : "\n")});
  endtask

  function automatic string digits(int n, int maxv);
    string s;
    s = "";
    repeat (n) s = {s, string'(8'("0" + $urandom_range(0, maxv)))};
    return s;
  endfunction

  function automatic string rnum(int ip, int fp);
    string s;
    s = digits(ip, 9);
    if (fp >= 0) s = {s, ".", digits(fp, 9)};
    return s;
  endfunction

  // random but mostly well-formed RMC sentence body
  function automatic string rand_body();
    string t, d, body;
    int k;
    t = {$sformatf("%02d%02d%02d", $urandom_range(0, 25), $urandom_range(0, 61),
                   $urandom_range(0, 61))};
    k = $urandom_range(0, 9);
    if (k == 0) t = digits($urandom_range(0, 8), 9);
    else if (k < 6) t = {t, ".", digits($urandom_range(0, 4), 9)};
    d = $sformatf("%02d%02d%02d", $urandom_range(0, 32), $urandom_range(0, 13),
                  $urandom_range(0, 99));
    if ($urandom_range(0, 9) == 0) d = digits($urandom_range(0, 8), 9);
    body = {"GPRMC,", t, ",", ($urandom_range(0, 3) ? "A" : "V"), ",",
            rnum($urandom_range(0, 5), $urandom_range(0, 2) ? $urandom_range(0, 8) : -1),
            ",", ($urandom_range(0, 1) ? "N" : "S"), ",",
            rnum($urandom_range(0, 6), $urandom_range(0, 2) ? $urandom_range(0, 8) : -1),
            ",", ($urandom_range(0, 1) ? "W" : "E"), ",",
            rnum($urandom_range(0, 6), $urandom_range(0, 8)), ",", rnum(3, 1), ",", d,
            ",,,A"};
    if ($urandom_range(0, 9) == 0) body = {body, ",X,Y,Z,Q"};
    if ($urandom_range(0, 9) == 0) body = {body.substr(0, $urandom_range(5, 40)), "Z"};
    return body;
  endfunction

  task automatic drain();
    while (fixes.owed.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  initial begin : stimulus
    int i;
    repeat (3) @(negedge clk);
    rst <= 0;
    // directed sentences: extremes, hemispheres, leap days, bad fields
    add_text("junk\r\n");
    add_sentence("GPRMC,235959.999,A,9959.99999,N,17959.99999,W,99999.99999,0,311299,,,A");
    add_sentence("GPRMC,000000,A,0000.0,S,00000.0,E,0,0,290204,,,A");
    add_sentence("GPRMC,123456.7,V,4807.038,N,01131.000,E,022.4,084.4,290200,003.1,W,A");
    add_sentence("GPRMC,240000.1234,A,12.3.4,N,1x,W,.,0,310499,,,A");
    add_sentence("GPRMC,1234,,99999999,NN,9999999.99,WW,22,0,000101,,,A");
    add_sentence("GPRMC,120000,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1", 1);
    add_sentence("GPRMC,120000,A,4807.038,N,01131.000,E,022.4,084.4,230394,,,A", 0);
    add_text("$GPRMC,1*\n$A*123\n$B*G1\n$C*,\n$D*\n$x,y$GPRMC,,,,,,,,,,,,,,,,,,*00\n");
    stream.push_back(rmc_pkg::CH_DOLLAR);
    stream.push_back(8'hFF);
    stream.push_back(8'h80);
    stream.push_back(8'h7F);
    add_text({"*", hex2(8'hFF ^ 8'h80 ^ 8'h7F), "\r"});
    while (stream.size()) send_byte(stream.pop_front());
    // receiver stalls long while bytes keep coming, so full must rise
    hold_pop = 1;
    for (i = 0; i < 6; i++) add_sentence(rand_body());
    while (stream.size()) send_byte(stream.pop_front());
    // random part
    while (sent < 1650) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 6)) stream.push_back($urandom_range(0, 255));
      end else add_sentence(rand_body(), $urandom_range(0, 7) != 0);
      if (sent > 1400) calm = 1;
      while (stream.size()) send_byte(stream.pop_front());
    end
    push <= 0;
    drain();
    if (fixes.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // generous limit on run time
  initial begin : watchdog
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end
endmodule
